// ----- rtl/dka_pkg.sv -----
// Package for the direction key autorepeat block: types, register indexes and reset values.
package dka_pkg;

    localparam int unsigned MASK_W  = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 16;

    localparam logic [POS_W-1:0]   UP_BIT_RST      = 5'd0;
    localparam logic [POS_W-1:0]   DOWN_BIT_RST    = 5'd1;
    localparam logic [POS_W-1:0]   LEFT_BIT_RST    = 5'd2;
    localparam logic [POS_W-1:0]   RIGHT_BIT_RST   = 5'd3;
    localparam logic [DELAY_W-1:0] FIRST_DLY_RST   = 16'd300;
    localparam logic [DELAY_W-1:0] HORIZ_DLY_RST   = 16'd250;
    localparam logic [DELAY_W-1:0] VERT_DLY_RST    = 16'd150;

    typedef enum logic [CIDX_W-1:0] {
        CFG_UP_BIT      = 3'd0,
        CFG_DOWN_BIT    = 3'd1,
        CFG_LEFT_BIT    = 3'd2,
        CFG_RIGHT_BIT   = 3'd3,
        CFG_FIRST_DLY   = 3'd4,
        CFG_HORIZ_DLY   = 3'd5,
        CFG_VERT_DLY    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_VERT  = 2'd2,
        MODE_HORIZ = 2'd3
    } t_mode;

    typedef struct packed {
        logic [POS_W-1:0]   up_bit;
        logic [POS_W-1:0]   down_bit;
        logic [POS_W-1:0]   left_bit;
        logic [POS_W-1:0]   right_bit;
        logic [DELAY_W-1:0] first_delay_ms;
        logic [DELAY_W-1:0] horizontal_delay_ms;
        logic [DELAY_W-1:0] vertical_delay_ms;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic [TIME_W-1:0]  start_time;
    } t_state;

    typedef struct packed {
        logic               emit;
        logic [MASK_W-1:0]  button_events;
    } t_step_res;

endpackage

// ----- rtl/dka_if.sv -----
// Handshake channel interfaces: poll input, event output and register write.
interface dka_in_if;
    logic                        valid;
    logic                        ready;
    logic [dka_pkg::MASK_W-1:0]  pressed_mask;
    logic [dka_pkg::MASK_W-1:0]  held_mask;
    logic [dka_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, pressed_mask, held_mask, now_ms, input ready);
    modport sink   (input valid, pressed_mask, held_mask, now_ms, output ready);
endinterface

interface dka_out_if;
    logic                        valid;
    logic                        ready;
    logic [dka_pkg::MASK_W-1:0]  button_events;

    modport source (output valid, button_events, input ready);
    modport sink   (input valid, button_events, output ready);
endinterface

interface dka_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dka_pkg::CIDX_W-1:0]  index;
    logic [dka_pkg::CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dka_step.sv -----
// Poll step logic: decides the event for one poll and the next repeat state.
module dka_step (
    input  dka_pkg::t_cfg                    i_cfg,
    input  dka_pkg::t_state                  i_state,
    input  logic [dka_pkg::MASK_W-1:0]       i_pressed_mask,
    input  logic [dka_pkg::MASK_W-1:0]       i_held_mask,
    input  logic [dka_pkg::TIME_W-1:0]       i_now_ms,
    output dka_pkg::t_state                  o_state,
    output dka_pkg::t_step_res               o_res
);
    import dka_pkg::*;

    logic [MASK_W-1:0]  w_u, w_d, w_l, w_r, w_dirs;
    logic [TIME_W-1:0]  w_elapsed;
    logic [DELAY_W-1:0] w_wait;
    logic               w_press, w_held_dir, w_due;
    logic [MASK_W-1:0]  w_sel;
    t_mode              w_sel_mode;

    assign w_u    = MASK_W'(1) << i_cfg.up_bit;
    assign w_d    = MASK_W'(1) << i_cfg.down_bit;
    assign w_l    = MASK_W'(1) << i_cfg.left_bit;
    assign w_r    = MASK_W'(1) << i_cfg.right_bit;
    assign w_dirs = w_u | w_d | w_l | w_r;

    assign w_press    = (i_pressed_mask != '0);
    assign w_held_dir = ((i_held_mask & w_dirs) != '0);
    assign w_elapsed  = i_now_ms - i_state.start_time;

    always_comb begin
        case (i_state.mode)
            MODE_FIRST: w_wait = i_cfg.first_delay_ms;
            MODE_HORIZ: w_wait = i_cfg.horizontal_delay_ms;
            default:    w_wait = i_cfg.vertical_delay_ms;
        endcase
    end

    // wait ends only when strictly more than the delay has gone by
    assign w_due = (i_state.mode != MODE_IDLE) && w_held_dir
                 && (w_elapsed > {{(TIME_W-DELAY_W){1'b0}}, w_wait});

    // up before down before left before right
    always_comb begin
        if ((i_held_mask & w_u) != '0) begin
            w_sel = w_u;
            w_sel_mode = MODE_VERT;
        end else if ((i_held_mask & w_d) != '0) begin
            w_sel = w_d;
            w_sel_mode = MODE_VERT;
        end else if ((i_held_mask & w_l) != '0) begin
            w_sel = w_l;
            w_sel_mode = MODE_HORIZ;
        end else begin
            w_sel = w_r;
            w_sel_mode = MODE_HORIZ;
        end
    end

    // next state
    always_comb begin
        o_state = i_state;
        if (w_press) begin
            if ((i_pressed_mask & w_dirs) != '0) begin
                o_state.mode       = MODE_FIRST;
                o_state.start_time = i_now_ms;
            end else begin
                o_state.mode = MODE_IDLE;
            end
        end else if (i_state.mode != MODE_IDLE && !w_held_dir) begin
            o_state.mode = MODE_IDLE;
        end else if (w_due) begin
            o_state.mode       = w_sel_mode;
            o_state.start_time = i_now_ms;
        end
    end

    // outputs
    always_comb begin
        o_res.emit          = 1'b0;
        o_res.button_events = i_pressed_mask;
        if (w_press) begin
            o_res.emit = 1'b1;
        end else if (w_due) begin
            o_res.emit          = 1'b1;
            o_res.button_events = w_sel;
        end
    end

endmodule

// ----- rtl/direction_key_autorepeat.sv -----
// Top level of the direction key autorepeat block: channel registers, state and register file.
//
//  channel  dir  payload                              transfer when
//  i_in     in   pressed_mask, held_mask, now_ms      i_in.valid & i_in.ready
//  o_out    out  button_events                        o_out.valid & o_out.ready
//  i_cfg    in   index (3 b), data (16 b)             i_cfg.valid & i_cfg.ready
//
// One poll per cycle sustained while the input stage does not stall. A poll is
// held in the input register, decided by the step logic, and its event is loaded
// into the result register when the poll advances, which sets o_out.valid.
// Synchronous active-low reset clears the repeat mode, the stamp and both valid
// flags, and loads the register file with its defaults. The input stage stalls
// only while it holds a poll that emits and the result register is full and
// not being taken.
module direction_key_autorepeat (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dka_in_if.sink    i_in,
    dka_out_if.source o_out,
    dka_cfg_if.sink   i_cfg
);
    import dka_pkg::*;

    // register file
    t_cfg               r_cfg;

    // input stage
    logic               r_in_valid;
    logic [MASK_W-1:0]  r_in_pressed;
    logic [MASK_W-1:0]  r_in_held;
    logic [TIME_W-1:0]  r_in_now;

    // repeat state
    t_state             r_state;
    t_state             n_state;

    // result stage
    logic               r_out_valid;
    logic [MASK_W-1:0]  r_out_events;

    t_step_res          w_res;
    logic               w_adv;
    logic               w_in_xfer;

    dka_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_pressed_mask (r_in_pressed),
        .i_held_mask    (r_in_held),
        .i_now_ms       (r_in_now),
        .o_state        (n_state),
        .o_res          (w_res)
    );

    // advance the held poll unless its event has nowhere to go
    assign w_adv     = r_in_valid && (!w_res.emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_xfer = i_in.valid && i_in.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.button_events = r_out_events;

    // register writes are always taken; an unknown index is dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_bit              <= UP_BIT_RST;
            r_cfg.down_bit            <= DOWN_BIT_RST;
            r_cfg.left_bit            <= LEFT_BIT_RST;
            r_cfg.right_bit           <= RIGHT_BIT_RST;
            r_cfg.first_delay_ms      <= FIRST_DLY_RST;
            r_cfg.horizontal_delay_ms <= HORIZ_DLY_RST;
            r_cfg.vertical_delay_ms   <= VERT_DLY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_UP_BIT:    r_cfg.up_bit              <= i_cfg.data[POS_W-1:0];
                CFG_DOWN_BIT:  r_cfg.down_bit            <= i_cfg.data[POS_W-1:0];
                CFG_LEFT_BIT:  r_cfg.left_bit            <= i_cfg.data[POS_W-1:0];
                CFG_RIGHT_BIT: r_cfg.right_bit           <= i_cfg.data[POS_W-1:0];
                CFG_FIRST_DLY: r_cfg.first_delay_ms      <= i_cfg.data[DELAY_W-1:0];
                CFG_HORIZ_DLY: r_cfg.horizontal_delay_ms <= i_cfg.data[DELAY_W-1:0];
                CFG_VERT_DLY:  r_cfg.vertical_delay_ms   <= i_cfg.data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage: load on transfer, drop once advanced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_pressed <= i_in.pressed_mask;
            r_in_held    <= i_in.held_mask;
            r_in_now     <= i_in.now_ms;
        end
    end

    // repeat state moves only when a poll advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= MODE_IDLE;
            r_state.start_time <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result stage: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.emit) begin
            r_out_events <= w_res.button_events;
        end
    end

`ifndef SYNTH
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid && r_state.mode == MODE_IDLE)
        else $error("reset left state or valid flags set");

    a_repeat_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res.emit && r_in_pressed == '0) |=> $onehot(r_out_events))
        else $error("repeat event is not a single direction");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_state.mode == MODE_IDLE && r_in_pressed == '0) |-> !w_res.emit)
        else $error("event emitted from idle without a press");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_out_events))
        else $error("stalled result overwritten");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |-> !i_in.ready)
        else $error("input taken while input stage is stalled");
`endif

endmodule
